// ===== sv/assert_macros.svh =====
// assertion macros shared by the denoise rtl
// expects a clock named clk and a synchronous active-high reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

// when trig holds, expr must hold at the next clock edge
`define ASSERT_NEXT(label, trig, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) \
    else $error(msg);

`endif

// ===== sv/bncd_pkg.sv =====
// shared types and constants for the binary neighbour-count denoise block
// no dependencies
package bncd_pkg;

  // register index, byte address is 4 times the index
  typedef enum logic [2:0] {
    REG_THRESHOLD = 3'd0,
    REG_WIDTH     = 3'd1,
    REG_HEIGHT    = 3'd2,
    REG_FILL      = 3'd3,
    REG_CLEAR     = 3'd4
  } reg_idx_t;

  // register reset values
  localparam logic [7:0]  THRESHOLD_RESET = 8'd98;
  localparam logic [10:0] WIDTH_RESET     = 11'd1024;
  localparam logic [10:0] HEIGHT_RESET    = 11'd1024;
  localparam logic [3:0]  FILL_RESET      = 4'd5;
  localparam logic [3:0]  CLEAR_RESET     = 4'd1;

  // input kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // output pixel codes
  localparam logic [7:0] PIX_BLACK = 8'd0;
  localparam logic [7:0] PIX_WHITE = 8'd255;

  // row store identifiers, three physical stores rotate through roles
  typedef logic [1:0] bank_t;
  localparam bank_t BANK_0 = 2'd0;
  localparam bank_t BANK_1 = 2'd1;
  localparam bank_t BANK_2 = 2'd2;

  // result queue depth, power of two
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_end;
  } result_t;

  // up to two results pushed per cycle, first one goes out first
  typedef struct packed {
    logic [1:0] cnt;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic [7:0] to_pixel(input logic white);
    return white ? PIX_WHITE : PIX_BLACK;
  endfunction

endpackage

// ===== sv/bncd_row_ram.sv =====
// one-bit-wide row store: one write port, one read port with registered data
// no dependencies
module bncd_row_ram #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic                     wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic                     rdata
);

  logic mem [DEPTH];

  // write and registered read, a read of the address being written sees old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/bncd_out_queue.sv =====
// result queue: takes up to two results per cycle, hands out one per transaction
// depends on bncd_pkg and assert_macros.svh
`include "assert_macros.svh"

module bncd_out_queue (
  input  logic              clk,
  input  logic              rst,
  input  bncd_pkg::push_t   push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output bncd_pkg::result_t out_data
);

  localparam int unsigned DEPTH = bncd_pkg::QUEUE_DEPTH;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  bncd_pkg::result_t entries [DEPTH];
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          pop;

  // head entry is the output, it only moves on a completed transaction
  assign out_valid = count != '0;
  assign out_data  = entries[head];
  assign pop       = out_valid && !out_stall;
  assign room      = count <= CW'(DEPTH - 2);

  always_comb begin
    count_next = count + CW'(push.cnt) - CW'(pop);
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      entries[tail] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      entries[tail + PW'(1)] <= push.second;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + PW'(push.cnt);
      count <= count_next;
      if (pop) begin
        head <= head + PW'(1);
      end
    end
  end

  `ASSERT_ALWAYS(push_needs_room, (push.cnt == 2'd0) || room, "push without room in result queue")
  `ASSERT_ALWAYS(count_in_range, count <= CW'(DEPTH), "result queue overfilled")
  `ASSERT_NEXT(pop_drains_one, pop && (push.cnt == 2'd0), count == $past(count) - CW'(1), "pop did not drain one entry")

endmodule

// ===== sv/binary_neighbour_count_denoise.sv =====
// binary 3x3 neighbour-count denoise, streaming; uses bncd_pkg, bncd_row_ram, bncd_out_queue
// a result goes through the input register and the result queue before it is offered
// throughput: one item per clock while the queue has room, set by the row stores
// (one read and one write port each); the queue absorbs the extra result of an end-of-row pixel
// reset: synchronous rst restores register defaults, clears counters and empties the queue;
// the row stores are not cleared and entries are defined once written
`include "assert_macros.svh"

module binary_neighbour_count_denoise #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // pixel input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [7:0]  gray_value,
  // filtered output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  pixel_out,
  output logic        frame_end
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);

  // item state carried from the input register to the result stage
  typedef struct packed {
    logic            pix;
    logic            flush_out;
    logic            fl_end;
    logic            out1;
    logic            out2;
    logic            interior;
    logic            bin;
    bncd_pkg::bank_t ab_bank;
    bncd_pkg::bank_t mid_bank;
    logic [AW-1:0]   wr_addr;
  } stage_t;

  // configuration registers
  logic [7:0]  threshold_level;
  logic [10:0] frame_width;
  logic [10:0] frame_height;
  logic [3:0]  fill_count;
  logic [3:0]  clear_count;
  logic        cfg_write;
  bncd_pkg::reg_idx_t reg_idx;

  // position and flush state
  logic [AW-1:0] col;
  logic [RW-1:0] row;
  logic [WW-1:0] flush_cnt;
  logic          flush_pending;
  bncd_pkg::bank_t ab_bank;
  bncd_pkg::bank_t mid_bank;
  bncd_pkg::bank_t inc_bank;

  // input side
  logic [WW-1:0] w;
  logic [HW-1:0] h;
  logic          acc;
  logic          is_pix;
  logic          pend_reset;
  logic [AW-1:0] col_base;
  logic [RW-1:0] row_base;
  logic [AW-1:0] c_eff;
  logic [RW-1:0] r_eff;
  logic          last_col;
  logic          last_row;
  logic          fl_live;
  logic          fl_end;
  logic          bin;
  logic [AW-1:0] rd_addr;
  stage_t        s1_next;

  // result stage
  logic          s1_valid;
  stage_t        s1;
  logic          s1_adv;
  logic          room;
  logic [2:0]    rdq;
  logic          rd_above;
  logic          rd_mid;
  logic          ab_p1;
  logic          ab_p2;
  logic          in_p1;
  logic          in_p2;
  logic          m_self;
  logic          left_updated_bit;
  logic [3:0]    z;
  logic          res1;
  logic          inc_we;
  logic          mid_we;
  bncd_pkg::push_t   push;
  bncd_pkg::result_t head;

  // register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = bncd_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_level <= bncd_pkg::THRESHOLD_RESET;
      frame_width     <= bncd_pkg::WIDTH_RESET;
      frame_height    <= bncd_pkg::HEIGHT_RESET;
      fill_count      <= bncd_pkg::FILL_RESET;
      clear_count     <= bncd_pkg::CLEAR_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        bncd_pkg::REG_THRESHOLD: threshold_level <= pwdata[7:0];
        bncd_pkg::REG_WIDTH:     frame_width     <= pwdata[10:0];
        bncd_pkg::REG_HEIGHT:    frame_height    <= pwdata[10:0];
        bncd_pkg::REG_FILL:      fill_count      <= pwdata[3:0];
        bncd_pkg::REG_CLEAR:     clear_count     <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bncd_pkg::REG_THRESHOLD: prdata = 32'(threshold_level);
      bncd_pkg::REG_WIDTH:     prdata = 32'(frame_width);
      bncd_pkg::REG_HEIGHT:    prdata = 32'(frame_height);
      bncd_pkg::REG_FILL:      prdata = 32'(fill_count);
      bncd_pkg::REG_CLEAR:     prdata = 32'(clear_count);
      default:                 prdata = '0;
    endcase
  end

  // effective frame size: zero acts as one, large values saturate
  always_comb begin
    if (frame_width == '0) begin
      w = WW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(frame_width);
    end
    if (frame_height == '0) begin
      h = HW'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(frame_height);
    end
  end

  // input transaction decode
  assign acc        = in_valid && !in_stall;
  assign is_pix     = kind == bncd_pkg::KIND_PIXEL;
  assign pend_reset = is_pix && flush_pending;
  assign col_base   = pend_reset ? '0 : col;
  assign row_base   = pend_reset ? '0 : row;
  assign c_eff      = (WW'(col_base) >= w) ? AW'(w - WW'(1)) : col_base;
  assign r_eff      = (HW'(row_base) >= h) ? RW'(h - HW'(1)) : row_base;
  assign last_col   = (WW'(c_eff) + WW'(1)) >= w;
  assign last_row   = (HW'(r_eff) + HW'(1)) >= h;
  assign fl_live    = flush_pending && (flush_cnt < w);
  assign fl_end     = (flush_cnt + WW'(1)) >= w;
  assign bin        = gray_value > threshold_level;
  assign rd_addr    = is_pix ? c_eff : flush_cnt[AW-1:0];

  always_comb begin
    s1_next.pix       = is_pix;
    s1_next.flush_out = !is_pix && fl_live;
    s1_next.fl_end    = fl_end;
    s1_next.out1      = is_pix && (r_eff != '0) && (c_eff != '0);
    s1_next.out2      = is_pix && (r_eff != '0) && last_col;
    s1_next.interior  = (r_eff >= RW'(2)) && (c_eff >= AW'(2));
    s1_next.bin       = bin;
    s1_next.ab_bank   = ab_bank;
    s1_next.mid_bank  = mid_bank;
    s1_next.wr_addr   = c_eff - AW'(1);
  end

  // counters, flush state and row store rotation
  always_ff @(posedge clk) begin
    if (rst) begin
      col           <= '0;
      row           <= '0;
      flush_cnt     <= '0;
      flush_pending <= 1'b0;
      ab_bank       <= bncd_pkg::BANK_0;
      mid_bank      <= bncd_pkg::BANK_1;
      inc_bank      <= bncd_pkg::BANK_2;
    end else if (acc) begin
      if (is_pix) begin
        flush_pending <= last_col && last_row;
        if (last_col) begin
          col      <= '0;
          ab_bank  <= mid_bank;
          mid_bank <= inc_bank;
          inc_bank <= ab_bank;
          if (last_row) begin
            row       <= '0;
            flush_cnt <= '0;
          end else begin
            row <= r_eff + RW'(1);
          end
        end else begin
          col <= c_eff + AW'(1);
          row <= r_eff;
        end
      end else if (fl_live) begin
        flush_cnt <= flush_cnt + WW'(1);
        if (fl_end) begin
          flush_pending <= 1'b0;
        end
      end else begin
        flush_pending <= 1'b0;
      end
    end
  end

  // input register
  assign s1_adv   = s1_valid && room;
  assign in_stall = s1_valid && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1 <= s1_next;
    end
  end

  // row stores, read at the accept edge, data lines up with the input register
  assign inc_we = acc && is_pix;
  assign mid_we = s1_adv && s1.pix && s1.out1 && s1.interior;

  for (genvar g = 0; g < 3; g++) begin : g_bank
    logic          we;
    logic          mid_sel;
    logic [AW-1:0] waddr;
    logic          wdata;

    assign mid_sel = mid_we && (s1.mid_bank == bncd_pkg::bank_t'(g));
    assign we      = mid_sel || (inc_we && (inc_bank == bncd_pkg::bank_t'(g)));
    assign waddr   = mid_sel ? s1.wr_addr : c_eff;
    assign wdata   = mid_sel ? res1 : bin;

    bncd_row_ram #(
      .DEPTH (MAX_WIDTH)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (acc),
      .raddr (rd_addr),
      .rdata (rdq[g])
    );
  end

  // pick read data by role
  always_comb begin
    unique case (s1.ab_bank)
      bncd_pkg::BANK_0: rd_above = rdq[0];
      bncd_pkg::BANK_1: rd_above = rdq[1];
      bncd_pkg::BANK_2: rd_above = rdq[2];
      default:          rd_above = 1'b0;
    endcase
    unique case (s1.mid_bank)
      bncd_pkg::BANK_0: rd_mid = rdq[0];
      bncd_pkg::BANK_1: rd_mid = rdq[1];
      bncd_pkg::BANK_2: rd_mid = rdq[2];
      default:          rd_mid = 1'b0;
    endcase
  end

  // black neighbour count around the middle-row pixel one column back
  always_comb begin
    z = 4'(!ab_p2) + 4'(!ab_p1) + 4'(!rd_above) + 4'(!left_updated_bit)
      + 4'(!rd_mid) + 4'(!in_p2) + 4'(!in_p1) + 4'(!s1.bin);
  end

  // fill is tested before clear
  always_comb begin
    if (s1.interior && (z >= fill_count)) begin
      res1 = 1'b0;
    end else if (s1.interior && (z <= clear_count)) begin
      res1 = 1'b1;
    end else begin
      res1 = m_self;
    end
  end

  // window shift registers, only pixels move them
  always_ff @(posedge clk) begin
    if (s1_adv && s1.pix) begin
      ab_p2  <= ab_p1;
      ab_p1  <= rd_above;
      in_p2  <= in_p1;
      in_p1  <= s1.bin;
      m_self <= rd_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_updated_bit <= 1'b0;
    end else if (s1_adv && s1.pix) begin
      if (s1.out2) begin
        left_updated_bit <= rd_mid;
      end else if (s1.out1) begin
        left_updated_bit <= res1;
      end
    end
  end

  // results into the queue, the end-of-row border pixel follows the filtered one
  always_comb begin
    push.cnt              = 2'd0;
    push.first.pixel      = bncd_pkg::to_pixel(rd_mid);
    push.first.frame_end  = 1'b0;
    push.second.pixel     = bncd_pkg::to_pixel(rd_mid);
    push.second.frame_end = 1'b0;
    if (s1_adv) begin
      if (s1.flush_out) begin
        push.cnt             = 2'd1;
        push.first.frame_end = s1.fl_end;
      end else if (s1.pix) begin
        push.cnt = 2'(s1.out1) + 2'(s1.out2);
        if (s1.out1) begin
          push.first.pixel = bncd_pkg::to_pixel(res1);
        end
      end
    end
  end

  bncd_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (head)
  );

  assign pixel_out = head.pixel;
  assign frame_end = head.frame_end;

  `ASSERT_ALWAYS(bank_roles_distinct, (ab_bank != mid_bank) && (mid_bank != inc_bank) && (ab_bank != inc_bank), "row store roles overlap")
  `ASSERT_ALWAYS(one_write_per_bank, !(inc_we && mid_we && (inc_bank == s1.mid_bank)), "two writes to one row store")
  `ASSERT_NEXT(rotate_on_row_end, acc && is_pix && last_col, (mid_bank == $past(inc_bank)) && (ab_bank == $past(mid_bank)), "row stores did not rotate")
  `ASSERT_ALWAYS(pixel_is_binary, !out_valid || (pixel_out == bncd_pkg::PIX_WHITE) || (pixel_out == bncd_pkg::PIX_BLACK), "output pixel not binary")

endmodule
